// ===== sv/ocr_pkg.sv =====
package ocr_pkg;

    localparam int ID_W    = 13;
    localparam int LVL_W   = 3;
    localparam int PAR_W   = 10;
    localparam int CRD_W   = 32;
    localparam int SZ_W    = 31;
    localparam int ST_W    = 2;
    localparam int OFF_W   = 19;
    localparam int SQ_IN_W = 64;
    localparam int SQ_RT_W = 32;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_RAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_Z   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEPEST  = 3'd7;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BEYOND = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT    = 2'd2;

    localparam logic [SZ_W-1:0] SIZE_MAX = 31'h7FFF_FFFF;

    // first id of each level: (8^L - 1) / 7
    localparam logic [OFF_W-1:0] LVL_OFF [0:7] = '{
        19'd0, 19'd1, 19'd9, 19'd73, 19'd585, 19'd4681, 19'd37449, 19'd299593
    };

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } t_center;

endpackage

// ===== sv/ocr_center_mem.sv =====
module ocr_center_mem #(
    parameter int DEPTH = 4681,
    parameter int AW    = 13
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output ocr_pkg::t_center o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  ocr_pkg::t_center i_wr_data
);
    import ocr_pkg::*;

    t_center r_mem [DEPTH];
    t_center r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/ocr_isqrt.sv =====
module ocr_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ocr_pkg::SQ_IN_W-1:0]  i_value,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [ocr_pkg::SQ_RT_W-1:0]  o_root
);
    import ocr_pkg::*;

    localparam int STEPS = SQ_RT_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = SQ_RT_W + 1;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SQ_IN_W-1:0] r_val;
    logic [REM_W-1:0]   r_rem;
    logic [SQ_RT_W-1:0] r_root;

    logic [REM_W+1:0]   w_shift;
    logic [REM_W+1:0]   w_trial;
    logic               w_fit;
    logic [REM_W+1:0]   w_diff;

    assign w_shift = {r_rem, r_val[SQ_IN_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_fit   = (w_shift >= w_trial);
    assign w_diff  = w_shift - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[SQ_IN_W-3:0], 2'b00};
            r_rem  <= w_fit ? w_diff[REM_W-1:0] : w_shift[REM_W-1:0];
            r_root <= {r_root[SQ_RT_W-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("square root restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a running root");
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0) else $error("step count moved while idle");

endmodule

// ===== sv/octree_cell_center_radius.sv =====
// Linear octree cell geometry. Each beat on the input channel carries a cell id; one result
// beat follows with the cell center, half diagonal, level, parent id and status. Items are
// handled one at a time: a new cell id is taken only in S_IDLE. S_IDLE takes the beat and
// issues the read of the parent center from the center memory. S_SIZE sizes the cell while
// that read lands. S_MOVE moves the center and writes it back. S_SQ runs the shared size
// multiplier and accumulates the sum of squared sizes. S_START starts the square root. S_WAIT
// waits on its 32 steps, two bits of the 64-bit sum per step. S_OUT loads the result
// register. A result that waits for the receiver holds the next item in S_OUT. The center
// memory holds 3x32 bits per cell and is not cleared: a cell's parent must have been sent
// before the cell, and the root (id 0) before anything else. Cell 0 reports the configured
// root center and radius. Write configuration only while the block is idle.
module octree_cell_center_radius #(
    parameter int MAX_LEVELS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ocr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ocr_pkg::ID_W-1:0]            i_cell_id,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ocr_pkg::CRD_W-1:0]    o_center_x,
    output logic signed [ocr_pkg::CRD_W-1:0]    o_center_y,
    output logic signed [ocr_pkg::CRD_W-1:0]    o_center_z,
    output logic [ocr_pkg::SZ_W-1:0]            o_radius,
    output logic [ocr_pkg::LVL_W-1:0]           o_cell_level,
    output logic [ocr_pkg::PAR_W-1:0]           o_parent_id,
    output logic [ocr_pkg::ST_W-1:0]            o_status
);
    import ocr_pkg::*;

    localparam int TBL_FULL = ((1 << (3 * (MAX_LEVELS + 1))) - 1) / 7;
    localparam int DEPTH    = (TBL_FULL > (1 << ID_W)) ? (1 << ID_W) : TBL_FULL;
    localparam int AW       = $clog2(DEPTH);
    localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LEVELS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SIZE  = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // configuration
    logic signed [CRD_W-1:0] r_root_x, r_root_y, r_root_z;
    logic [SZ_W-1:0]         r_root_rad;
    logic [SZ_W-1:0]         r_leaf_x, r_leaf_y, r_leaf_z;
    logic [LVL_W-1:0]        r_deep_cfg;

    logic [2:0]              r_state;
    logic [ID_W-1:0]         r_id;
    logic [LVL_W-1:0]        r_lvl;
    logic [ID_W-1:0]         r_parent;
    logic [2:0]              r_seq;
    logic                    r_beyond;
    logic                    r_is_root;
    logic [LVL_W-1:0]        r_shift;
    logic [SZ_W-1:0]         r_dx, r_dy, r_dz;
    logic                    r_size_sat;
    logic                    r_sat;
    t_center                 r_ctr;
    logic [1:0]              r_sq_cnt;
    logic [2*SZ_W-1:0]       r_prod;
    logic [SQ_IN_W-1:0]      r_sum;

    logic                    r_out_valid;
    t_center                 r_out_ctr;
    logic [SZ_W-1:0]         r_out_rad;
    logic [LVL_W-1:0]        r_out_lvl;
    logic [PAR_W-1:0]        r_out_par;
    logic [ST_W-1:0]         r_out_st;

    logic [LVL_W-1:0]        w_deep;
    logic [LVL_W-1:0]        w_lvl;
    logic [ID_W-1:0]         w_rel;
    logic [ID_W-1:0]         w_parent;
    logic                    w_accept;
    logic                    w_out_free;
    t_center                 w_rd;
    t_center                 w_ctr;
    logic                    w_ctr_sat;
    logic                    w_wr_en;
    logic [SZ_W-1:0]         w_mul_in;
    logic                    w_sq_busy;
    logic                    w_sq_done;
    logic [SQ_RT_W-1:0]      w_sq_root;
    logic [SZ_W:0]           w_sx, w_sy, w_sz;
    logic [CRD_W:0]          w_mx, w_my, w_mz;

    function automatic logic [SZ_W:0] axis_size(input logic [SZ_W-1:0] leaf,
                                                input logic [LVL_W-1:0] sh);
        logic [SZ_W+5:0] s;
        logic            sat;
        s   = {6'b0, leaf} << sh;
        sat = |s[SZ_W+5:SZ_W];
        return {sat, sat ? SIZE_MAX : s[SZ_W-1:0]};
    endfunction

    function automatic logic [CRD_W:0] move_center(input logic signed [CRD_W-1:0] p,
                                                   input logic [SZ_W-1:0] size,
                                                   input logic plus);
        logic signed [CRD_W+1:0] c;
        logic signed [CRD_W+1:0] h;
        logic                    sat;
        h   = signed'({4'b0, size[SZ_W-1:1]});
        c   = plus ? {{2{p[CRD_W-1]}}, p} + h : {{2{p[CRD_W-1]}}, p} - h;
        sat = (c[CRD_W+1:CRD_W-1] != 3'b000) && (c[CRD_W+1:CRD_W-1] != 3'b111);
        if (sat) begin
            return {1'b1, c[CRD_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return {1'b0, c[CRD_W-1:0]};
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_x   <= '0;
            r_root_y   <= '0;
            r_root_z   <= '0;
            r_root_rad <= '0;
            r_leaf_x   <= SZ_W'(65536);
            r_leaf_y   <= SZ_W'(65536);
            r_leaf_z   <= SZ_W'(65536);
            r_deep_cfg <= LVL_W'(4);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROOT_X:   r_root_x   <= i_cfg_data;
                CFG_ROOT_Y:   r_root_y   <= i_cfg_data;
                CFG_ROOT_Z:   r_root_z   <= i_cfg_data;
                CFG_ROOT_RAD: r_root_rad <= i_cfg_data[SZ_W-1:0];
                CFG_LEAF_X:   r_leaf_x   <= i_cfg_data[SZ_W-1:0];
                CFG_LEAF_Y:   r_leaf_y   <= i_cfg_data[SZ_W-1:0];
                CFG_LEAF_Z:   r_leaf_z   <= i_cfg_data[SZ_W-1:0];
                CFG_DEEPEST:  r_deep_cfg <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_deep = (r_deep_cfg < MAX_LVL) ? r_deep_cfg : MAX_LVL;

    always_comb begin
        w_lvl = '0;
        for (int k = 1; k < 8; k++) begin
            if ({{(OFF_W-ID_W){1'b0}}, i_cell_id} >= LVL_OFF[k]) begin
                w_lvl = LVL_W'(k);
            end
        end
    end

    assign w_rel    = i_cell_id - LVL_OFF[w_lvl][ID_W-1:0];
    assign w_parent = (i_cell_id == '0) ? '0 :
                      ({3'b000, w_rel[ID_W-1:3]} + LVL_OFF[w_lvl - 3'd1][ID_W-1:0]);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    ocr_center_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_parent[AW-1:0]),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_id[AW-1:0]),
        .i_wr_data (w_ctr)
    );

    assign w_sx = axis_size(r_leaf_x, r_shift);
    assign w_sy = axis_size(r_leaf_y, r_shift);
    assign w_sz = axis_size(r_leaf_z, r_shift);

    assign w_mx = move_center(w_rd.x, r_dx, r_seq[0]);
    assign w_my = move_center(w_rd.y, r_dy, r_seq[1]);
    assign w_mz = move_center(w_rd.z, r_dz, r_seq[2]);

    always_comb begin
        if (r_is_root) begin
            w_ctr.x   = r_root_x;
            w_ctr.y   = r_root_y;
            w_ctr.z   = r_root_z;
            w_ctr_sat = 1'b0;
        end else begin
            w_ctr.x   = w_mx[CRD_W-1:0];
            w_ctr.y   = w_my[CRD_W-1:0];
            w_ctr.z   = w_mz[CRD_W-1:0];
            w_ctr_sat = w_mx[CRD_W] | w_my[CRD_W] | w_mz[CRD_W];
        end
    end

    assign w_wr_en = (r_state == S_MOVE) && !r_beyond;

    always_comb begin
        case (r_sq_cnt)
            2'd0:    w_mul_in = r_dx;
            2'd1:    w_mul_in = r_dy;
            2'd2:    w_mul_in = r_dz;
            default: w_mul_in = '0;
        endcase
    end

    ocr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_value (r_sum),
        .o_busy  (w_sq_busy),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sq_cnt    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SIZE;
                    end
                end
                S_SIZE: r_state <= S_MOVE;
                S_MOVE: begin
                    r_sq_cnt <= '0;
                    r_state  <= S_SQ;
                end
                S_SQ: begin
                    r_sq_cnt <= r_sq_cnt + 1'b1;
                    if (r_sq_cnt == 2'd3) begin
                        r_state <= S_START;
                    end
                end
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_sq_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id      <= i_cell_id;
            r_lvl     <= w_lvl;
            r_parent  <= w_parent;
            r_seq     <= w_rel[2:0];
            r_beyond  <= (w_lvl > w_deep);
            r_is_root <= (i_cell_id == '0);
            r_shift   <= w_deep - w_lvl;
        end
        if (r_state == S_SIZE) begin
            r_dx       <= w_sx[SZ_W-1:0];
            r_dy       <= w_sy[SZ_W-1:0];
            r_dz       <= w_sz[SZ_W-1:0];
            r_size_sat <= w_sx[SZ_W] | w_sy[SZ_W] | w_sz[SZ_W];
        end
        if (r_state == S_MOVE) begin
            r_ctr  <= w_ctr;
            r_sat  <= r_size_sat | w_ctr_sat;
            r_prod <= '0;
            r_sum  <= '0;
        end
        if (r_state == S_SQ) begin
            r_prod <= w_mul_in * w_mul_in;
            r_sum  <= r_sum + {2'b00, r_prod};
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_lvl <= r_lvl;
            r_out_par <= r_parent[PAR_W-1:0];
            if (r_beyond) begin
                r_out_ctr <= '0;
                r_out_rad <= '0;
                r_out_st  <= ST_BEYOND;
            end else if (r_is_root) begin
                r_out_ctr <= r_ctr;
                r_out_rad <= r_root_rad;
                r_out_st  <= ST_OK;
            end else begin
                r_out_ctr <= r_ctr;
                r_out_rad <= w_sq_root[SQ_RT_W-1:1];
                r_out_st  <= r_sat ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_center_x   = r_out_ctr.x;
    assign o_center_y   = r_out_ctr.y;
    assign o_center_z   = r_out_ctr.z;
    assign o_radius     = r_out_rad;
    assign o_cell_level = r_out_lvl;
    assign o_parent_id  = r_out_par;
    assign o_status     = r_out_st;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_SIZE) else $error("accepted beat did not start work");
    a_root_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && w_sq_done) |=> r_state == S_OUT)
        else $error("finished root not taken");
    a_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_sq_busy) else $error("input taken while root unit runs");
    a_beyond_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BEYOND) |-> (o_radius == '0 && o_center_x == '0))
        else $error("out-of-tree cell carries geometry");

endmodule
